// File: design/hsv_threshold_blob_centroid_defines.svh
// Assertion macros used by the checker file of the centroid block
`ifndef HSV_THRESHOLD_BLOB_CENTROID_DEFINES_SVH
`define HSV_THRESHOLD_BLOB_CENTROID_DEFINES_SVH

// Clocked check, masked while reset is asserted
`define HSVTB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also holds during reset
`define HSVTB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/hsvtb_pkg.sv
// Shared types, constants and defaults of the HSV blob centroid block
package hsvtb_pkg;

  // Default geometry and fixed point format
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;
  localparam int FRAC_BITS_DEF  = 4;

  // Field and accumulator widths
  localparam int PIX_W    = 8;
  localparam int CENTER_W = 11;
  localparam int CNT_W    = 23;
  localparam int SUM_W    = 34;
  localparam int OUT_W    = 16;
  localparam int OUT_POS_MAX = 2 ** (OUT_W - 1) - 1;

  // Configuration port
  localparam int APB_DW = 32;
  localparam int APB_AW = 5;
  localparam int REG_IDX_W = 3;

  // Register reset values
  localparam logic [PIX_W-1:0]    HUE_LOW_RST  = 8'd55;
  localparam logic [PIX_W-1:0]    HUE_HIGH_RST = 8'd95;
  localparam logic [PIX_W-1:0]    SAT_LOW_RST  = 8'd125;
  localparam logic [PIX_W-1:0]    SAT_HIGH_RST = 8'd255;
  localparam logic [PIX_W-1:0]    VAL_LOW_RST  = 8'd25;
  localparam logic [PIX_W-1:0]    VAL_HIGH_RST = 8'd135;
  localparam logic [CENTER_W-1:0] CENTER_X_RST = 11'd320;
  localparam logic [CENTER_W-1:0] CENTER_Y_RST = 11'd240;

  // Register map, word index
  typedef enum logic [REG_IDX_W-1:0] {
    REG_HUE_LOW  = 3'd0,
    REG_HUE_HIGH = 3'd1,
    REG_SAT_LOW  = 3'd2,
    REG_SAT_HIGH = 3'd3,
    REG_VAL_LOW  = 3'd4,
    REG_VAL_HIGH = 3'd5,
    REG_CENTER_X = 3'd6,
    REG_CENTER_Y = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0]    hue_low;
    logic [PIX_W-1:0]    hue_high;
    logic [PIX_W-1:0]    sat_low;
    logic [PIX_W-1:0]    sat_high;
    logic [PIX_W-1:0]    val_low;
    logic [PIX_W-1:0]    val_high;
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic acc_en;
    logic prod_en;
    logic diff_en;
    logic start_x;
    logic start_y;
    logic store_x;
    logic store_y;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// File: design/hsvtb_if.sv
// Pixel and centroid stream interfaces
interface hsvtb_pix_if;
  logic                          valid;
  logic                          ready;
  logic [hsvtb_pkg::PIX_W-1:0]   pix_hue;
  logic [hsvtb_pkg::PIX_W-1:0]   pix_sat;
  logic [hsvtb_pkg::PIX_W-1:0]   pix_val;
  logic                          line_end;
  logic                          frame_end;

  modport source (output valid, pix_hue, pix_sat, pix_val, line_end, frame_end,
                  input ready);
  modport sink (input valid, pix_hue, pix_sat, pix_val, line_end, frame_end,
                output ready);
endinterface

interface hsvtb_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [hsvtb_pkg::OUT_W-1:0]  centroid_x;
  logic signed [hsvtb_pkg::OUT_W-1:0]  centroid_y;
  logic                                no_pixels;

  modport source (output valid, centroid_x, centroid_y, no_pixels, input ready);
  modport sink (input valid, centroid_x, centroid_y, no_pixels, output ready);
endinterface

// File: design/hsv_threshold_blob_centroid.sv
// Throughput: one pixel per cycle within a frame; the pixel channel stalls after frame_end.
// After the frame_end beat the sequencer forms the products and the signed distances, then
//   divides x then y on the shared one-bit-per-cycle divider, then loads the result.
// A pixel that does not end a frame produces no result.
// Reset: asynchronous, active low; clears positions, moments and the output valid flag
//   and loads the configuration defaults. No clearing pass is needed.
module hsv_threshold_blob_centroid #(
  parameter int MAX_WIDTH  = hsvtb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = hsvtb_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = hsvtb_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  hsvtb_pix_if.sink                     pix_i,
  hsvtb_res_if.source                   res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hsvtb_pkg::APB_AW-1:0]  paddr,
  input  logic [hsvtb_pkg::APB_DW-1:0]  pwdata,
  output logic [hsvtb_pkg::APB_DW-1:0]  prdata,
  output logic                          pready
);

  hsvtb_pkg::cfg_t cfg;
  hsvtb_pkg::cmd_t cmd;
  hsvtb_pkg::sts_t sts;
  logic            pix_ready;

  assign pix_i.ready = pix_ready;

  hsvtb_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  hsvtb_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pix_valid_i     (pix_i.valid),
    .pix_frame_end_i (pix_i.frame_end),
    .pix_ready_o     (pix_ready),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  hsvtb_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .pix_hue_i    (pix_i.pix_hue),
    .pix_sat_i    (pix_i.pix_sat),
    .pix_val_i    (pix_i.pix_val),
    .line_end_i   (pix_i.line_end),
    .frame_end_i  (pix_i.frame_end),
    .res_ready_i  (res_o.ready),
    .res_valid_o  (res_o.valid),
    .centroid_x_o (res_o.centroid_x),
    .centroid_y_o (res_o.centroid_y),
    .no_pixels_o  (res_o.no_pixels)
  );

endmodule

// File: design/hsvtb_regs.sv
// APB configuration registers: color ranges and centroid reference
module hsvtb_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel_i,
  input  logic                             penable_i,
  input  logic                             pwrite_i,
  input  logic [hsvtb_pkg::APB_AW-1:0]     paddr_i,
  input  logic [hsvtb_pkg::APB_DW-1:0]     pwdata_i,
  output logic [hsvtb_pkg::APB_DW-1:0]     prdata_o,
  output logic                             pready_o,
  output hsvtb_pkg::cfg_t                  cfg_o
);

  hsvtb_pkg::cfg_t      cfg_q;
  hsvtb_pkg::reg_idx_e  idx;
  logic                 wr_en;

  assign idx      = hsvtb_pkg::reg_idx_e'(paddr_i[hsvtb_pkg::APB_AW-1:2]);
  assign wr_en    = psel_i && penable_i && pwrite_i;
  assign pready_o = 1'b1;
  assign cfg_o    = cfg_q;

  // Write a register on the access beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hue_low  <= hsvtb_pkg::HUE_LOW_RST;
      cfg_q.hue_high <= hsvtb_pkg::HUE_HIGH_RST;
      cfg_q.sat_low  <= hsvtb_pkg::SAT_LOW_RST;
      cfg_q.sat_high <= hsvtb_pkg::SAT_HIGH_RST;
      cfg_q.val_low  <= hsvtb_pkg::VAL_LOW_RST;
      cfg_q.val_high <= hsvtb_pkg::VAL_HIGH_RST;
      cfg_q.center_x <= hsvtb_pkg::CENTER_X_RST;
      cfg_q.center_y <= hsvtb_pkg::CENTER_Y_RST;
    end else if (wr_en) begin
      case (idx)
        hsvtb_pkg::REG_HUE_LOW:  cfg_q.hue_low  <= pwdata_i[hsvtb_pkg::PIX_W-1:0];
        hsvtb_pkg::REG_HUE_HIGH: cfg_q.hue_high <= pwdata_i[hsvtb_pkg::PIX_W-1:0];
        hsvtb_pkg::REG_SAT_LOW:  cfg_q.sat_low  <= pwdata_i[hsvtb_pkg::PIX_W-1:0];
        hsvtb_pkg::REG_SAT_HIGH: cfg_q.sat_high <= pwdata_i[hsvtb_pkg::PIX_W-1:0];
        hsvtb_pkg::REG_VAL_LOW:  cfg_q.val_low  <= pwdata_i[hsvtb_pkg::PIX_W-1:0];
        hsvtb_pkg::REG_VAL_HIGH: cfg_q.val_high <= pwdata_i[hsvtb_pkg::PIX_W-1:0];
        hsvtb_pkg::REG_CENTER_X: cfg_q.center_x <= pwdata_i[hsvtb_pkg::CENTER_W-1:0];
        hsvtb_pkg::REG_CENTER_Y: cfg_q.center_y <= pwdata_i[hsvtb_pkg::CENTER_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (idx)
      hsvtb_pkg::REG_HUE_LOW:  prdata_o = hsvtb_pkg::APB_DW'(cfg_q.hue_low);
      hsvtb_pkg::REG_HUE_HIGH: prdata_o = hsvtb_pkg::APB_DW'(cfg_q.hue_high);
      hsvtb_pkg::REG_SAT_LOW:  prdata_o = hsvtb_pkg::APB_DW'(cfg_q.sat_low);
      hsvtb_pkg::REG_SAT_HIGH: prdata_o = hsvtb_pkg::APB_DW'(cfg_q.sat_high);
      hsvtb_pkg::REG_VAL_LOW:  prdata_o = hsvtb_pkg::APB_DW'(cfg_q.val_low);
      hsvtb_pkg::REG_VAL_HIGH: prdata_o = hsvtb_pkg::APB_DW'(cfg_q.val_high);
      hsvtb_pkg::REG_CENTER_X: prdata_o = hsvtb_pkg::APB_DW'(cfg_q.center_x);
      hsvtb_pkg::REG_CENTER_Y: prdata_o = hsvtb_pkg::APB_DW'(cfg_q.center_y);
      default:                 prdata_o = '0;
    endcase
  end

endmodule

// File: design/hsvtb_div.sv
// Restoring unsigned divider, one quotient bit per cycle
module hsvtb_div #(
  parameter int NUM_W = 38,
  parameter int DEN_W = 23
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int STEP_W = $clog2(NUM_W);

  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [NUM_W-1:0]  quo_q;
  logic [DEN_W-1:0]  den_q;
  logic [STEP_W-1:0] step_q;
  logic              run_q;
  logic              done_q;
  logic [DEN_W:0]    shifted;
  logic              fits;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    shifted = {rem_q, quo_q[NUM_W-1]};
    fits    = shifted >= {1'b0, den_q};
    rem_d   = fits ? DEN_W'(shifted - {1'b0, den_q}) : shifted[DEN_W-1:0];
  end

  // Control: run for NUM_W steps, pulse done after the last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= STEP_W'(NUM_W - 1);
      end else if (run_q) begin
        if (step_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[NUM_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: design/hsvtb_ctrl.sv
// Frame sequencer: accumulate pixels, then run the centroid divisions
module hsvtb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pix_valid_i,
  input  logic              pix_frame_end_i,
  output logic              pix_ready_o,
  input  hsvtb_pkg::sts_t   sts_i,
  output hsvtb_pkg::cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    ST_ACC,
    ST_MUL,
    ST_DIFF,
    ST_STX,
    ST_WX,
    ST_STY,
    ST_WY,
    ST_OUT
  } state_e;

  state_e state_q, state_d;
  logic   beat;

  assign pix_ready_o = (state_q == ST_ACC);
  assign beat        = pix_valid_i && pix_ready_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_ACC: begin
        cmd_o.acc_en = beat;
        if (beat && pix_frame_end_i) state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.prod_en = 1'b1;
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.diff_en = 1'b1;
        state_d = ST_STX;
      end
      ST_STX: begin
        cmd_o.start_x = 1'b1;
        state_d = ST_WX;
      end
      ST_WX: begin
        if (sts_i.div_done) begin
          cmd_o.store_x = 1'b1;
          state_d = ST_STY;
        end
      end
      ST_STY: begin
        cmd_o.start_y = 1'b1;
        state_d = ST_WY;
      end
      ST_WY: begin
        if (sts_i.div_done) begin
          cmd_o.store_y = 1'b1;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // Hold until the output register can take the result
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_ACC;
        end
      end
      default: state_d = ST_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACC;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: design/hsvtb_dp.sv
// Datapath: threshold, moment accumulators, centroid arithmetic, output register
module hsvtb_dp #(
  parameter int MAX_WIDTH  = hsvtb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = hsvtb_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = hsvtb_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  hsvtb_pkg::cfg_t                     cfg_i,
  input  hsvtb_pkg::cmd_t                     cmd_i,
  output hsvtb_pkg::sts_t                     sts_o,
  input  logic [hsvtb_pkg::PIX_W-1:0]         pix_hue_i,
  input  logic [hsvtb_pkg::PIX_W-1:0]         pix_sat_i,
  input  logic [hsvtb_pkg::PIX_W-1:0]         pix_val_i,
  input  logic                                line_end_i,
  input  logic                                frame_end_i,
  input  logic                                res_ready_i,
  output logic                                res_valid_o,
  output logic signed [hsvtb_pkg::OUT_W-1:0]  centroid_x_o,
  output logic signed [hsvtb_pkg::OUT_W-1:0]  centroid_y_o,
  output logic                                no_pixels_o
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int CNT_W  = hsvtb_pkg::CNT_W;
  localparam int SUM_W  = hsvtb_pkg::SUM_W;
  localparam int OUT_W  = hsvtb_pkg::OUT_W;
  localparam int DIFF_W = SUM_W + 1;
  localparam int NUM_W  = SUM_W + FRAC_BITS;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_HEIGHT - 1);

  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [SUM_W-1:0]  sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic [SUM_W-1:0]  prod_x_q, prod_y_q;
  logic [DIFF_W-1:0] dx_q, dy_q;
  logic [CNT_W-1:0]  den_q;
  logic              empty_q;
  logic [OUT_W-1:0]  qx_q, qy_q;
  logic              out_valid_q;
  logic [OUT_W-1:0]  out_x_q, out_y_q;
  logic              out_np_q;

  logic              keep;
  logic [CNT_W:0]    cnt_inc;
  logic [SUM_W:0]    sx_inc, sy_inc;
  logic [DIFF_W-1:0] mag_x, mag_y, mag_sel;
  logic [NUM_W-1:0]  div_num;
  logic              div_done;
  logic [NUM_W-1:0]  quo;
  logic              neg_sel;
  logic [OUT_W-1:0]  sat_val;

  // Inclusive range test on all three channels
  assign keep = (pix_hue_i >= cfg_i.hue_low) && (pix_hue_i <= cfg_i.hue_high) &&
                (pix_sat_i >= cfg_i.sat_low) && (pix_sat_i <= cfg_i.sat_high) &&
                (pix_val_i >= cfg_i.val_low) && (pix_val_i <= cfg_i.val_high);

  // Saturating moment updates
  always_comb begin
    cnt_inc = {1'b0, cnt_q} + 1'b1;
    sx_inc  = {1'b0, sum_x_q} + (SUM_W + 1)'(col_q);
    sy_inc  = {1'b0, sum_y_q} + (SUM_W + 1)'(row_q);
    cnt_d   = cnt_inc[CNT_W] ? '1 : cnt_inc[CNT_W-1:0];
    sum_x_d = sx_inc[SUM_W] ? '1 : sx_inc[SUM_W-1:0];
    sum_y_d = sy_inc[SUM_W] ? '1 : sy_inc[SUM_W-1:0];
  end

  // Advance raster position; clear it on the last pixel of the frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.acc_en) begin
      if (frame_end_i) begin
        col_q <= '0;
        row_q <= '0;
      end else if (line_end_i) begin
        col_q <= '0;
        if (row_q < ROW_LAST) row_q <= row_q + 1'b1;
      end else if (col_q < COL_LAST) begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // Accumulate kept pixels; drop the moments once they are snapshotted
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      sum_x_q <= '0;
      sum_y_q <= '0;
    end else if (cmd_i.diff_en) begin
      cnt_q   <= '0;
      sum_x_q <= '0;
      sum_y_q <= '0;
    end else if (cmd_i.acc_en && keep) begin
      cnt_q   <= cnt_d;
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
    end
  end

  // Reference times count, then signed distances: sum minus product for x, product minus sum for y
  always_ff @(posedge clk_i) begin
    if (cmd_i.prod_en) begin
      prod_x_q <= {{(SUM_W - hsvtb_pkg::CENTER_W){1'b0}}, cfg_i.center_x} *
                  {{(SUM_W - CNT_W){1'b0}}, cnt_q};
      prod_y_q <= {{(SUM_W - hsvtb_pkg::CENTER_W){1'b0}}, cfg_i.center_y} *
                  {{(SUM_W - CNT_W){1'b0}}, cnt_q};
    end
    if (cmd_i.diff_en) begin
      dx_q    <= {1'b0, sum_x_q} - {1'b0, prod_x_q};
      dy_q    <= {1'b0, prod_y_q} - {1'b0, sum_y_q};
      den_q   <= cnt_q;
      empty_q <= (cnt_q == '0);
    end
  end

  // Magnitudes feed the divider, scaled by the fraction bits
  assign mag_x   = dx_q[DIFF_W-1] ? (~dx_q + 1'b1) : dx_q;
  assign mag_y   = dy_q[DIFF_W-1] ? (~dy_q + 1'b1) : dy_q;
  assign mag_sel = cmd_i.start_y ? mag_y : mag_x;
  assign div_num = NUM_W'(mag_sel[SUM_W-1:0]) << FRAC_BITS;

  hsvtb_div #(
    .NUM_W (NUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start_x || cmd_i.start_y),
    .num_i   (div_num),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // Apply sign and clamp the quotient to the output range
  assign neg_sel = cmd_i.store_y ? dy_q[DIFF_W-1] : dx_q[DIFF_W-1];
  always_comb begin
    if (!neg_sel) begin
      sat_val = (quo > NUM_W'(hsvtb_pkg::OUT_POS_MAX)) ?
                OUT_W'(hsvtb_pkg::OUT_POS_MAX) : quo[OUT_W-1:0];
    end else begin
      sat_val = (quo > NUM_W'(hsvtb_pkg::OUT_POS_MAX + 1)) ?
                {1'b1, {(OUT_W - 1){1'b0}}} : OUT_W'(0) - quo[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_x) qx_q <= sat_val;
    if (cmd_i.store_y) qy_q <= sat_val;
  end

  // Output register: load when free, drop when the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_x_q  <= empty_q ? '0 : qx_q;
      out_y_q  <= empty_q ? '0 : qy_q;
      out_np_q <= empty_q;
    end
  end

  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || res_ready_i;
  assign res_valid_o    = out_valid_q;
  assign centroid_x_o   = out_x_q;
  assign centroid_y_o   = out_y_q;
  assign no_pixels_o    = out_np_q;

endmodule

// File: design/hsvtb_checker.sv
// Port-level checks of the centroid block and their bind to the top level
`include "hsv_threshold_blob_centroid_defines.svh"

module hsvtb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          pix_valid_i,
  input logic                          pix_ready_i,
  input logic                          pix_frame_end_i,
  input logic                          res_valid_i,
  input logic                          res_ready_i,
  input logic [hsvtb_pkg::OUT_W-1:0]   centroid_x_i,
  input logic [hsvtb_pkg::OUT_W-1:0]   centroid_y_i,
  input logic                          no_pixels_i
);

  // A stalled result stays offered
  `HSVTB_ASSERT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i |=> res_valid_i, "result dropped while stalled")

  // A stalled result keeps its payload
  `HSVTB_ASSERT(a_res_stable, clk_i, rst_ni, res_valid_i && !res_ready_i |=> $stable(centroid_x_i) && $stable(centroid_y_i) && $stable(no_pixels_i), "result changed while stalled")

  // An empty frame reports a zero centroid
  `HSVTB_ASSERT(a_empty_zero, clk_i, rst_ni, res_valid_i && no_pixels_i |-> centroid_x_i == '0 && centroid_y_i == '0, "empty frame with nonzero centroid")

  // The end of a frame blocks further pixels while the centroid is computed
  `HSVTB_ASSERT(a_frame_busy, clk_i, rst_ni, pix_valid_i && pix_ready_i && pix_frame_end_i |=> !pix_ready_i, "pixel taken during centroid computation")

  // A cycle spent in reset leaves no result offered
  `HSVTB_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !res_valid_i, "result valid during reset")

endmodule

bind hsv_threshold_blob_centroid hsvtb_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .pix_valid_i     (pix_i.valid),
  .pix_ready_i     (pix_i.ready),
  .pix_frame_end_i (pix_i.frame_end),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .centroid_x_i    (res_o.centroid_x),
  .centroid_y_i    (res_o.centroid_y),
  .no_pixels_i     (res_o.no_pixels)
);
